@@ hw/rtl/ais_pkg.sv @@
// shared types and constants for the alias ip receive steering block
package ais_pkg;

  // request type codes on the input channel
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_DEL   = 2'd2;

  // configuration register indexes
  localparam logic CFG_PRIMARY_IP = 1'b0;
  localparam logic CFG_LINK_ETH   = 1'b1;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // command status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_IN_USE  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // frame parsing constants
  localparam int unsigned COUNT_W   = 7;
  localparam logic [6:0]  COUNT_MAX = 7'd127;
  localparam logic [6:0]  POS_ET_HI   = 7'd12;
  localparam logic [6:0]  POS_ET_LO   = 7'd13;
  localparam logic [6:0]  POS_INNER_HI = 7'd16;
  localparam logic [6:0]  POS_INNER_LO = 7'd17;
  localparam logic [6:0]  OFF_ETH   = 7'd14;
  localparam logic [6:0]  OFF_VLAN  = 7'd18;
  localparam logic [6:0]  IP_DST_FIRST  = 7'd16;
  localparam logic [6:0]  IP_DST_LAST   = 7'd19;
  localparam logic [6:0]  ARP_DST_FIRST = 7'd24;
  localparam logic [6:0]  ARP_DST_LAST  = 7'd27;
  localparam logic [6:0]  IP_HDR_LEN  = 7'd20;
  localparam logic [6:0]  ARP_HDR_LEN = 7'd28;
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_RARP = 16'h8035;
  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;

  // job kinds passed from the parser to the table engine
  typedef enum logic [1:0] {
    JOB_FRAME = 2'd0,
    JOB_ADD   = 2'd1,
    JOB_DEL   = 2'd2
  } job_kind_e;

  // one queued job
  typedef struct packed {
    job_kind_e   kind;
    logic        dest_ok;
    logic [31:0] addr;
  } job_t;

endpackage

@@ hw/rtl/ais_front.sv @@
// front end: accepts requests, parses frame bytes, emits jobs
module ais_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             link_eth_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_last_i,
  input  logic [31:0]      alias_address_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ais_pkg::job_t    push_job_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] et_q, et_d;
  logic        vlan_q, vlan_d;
  logic [3:0]  ver_q, ver_d;
  logic [31:0] dest_q, dest_d;

  logic        req_acc;
  logic        byte_in;
  logic [6:0]  off;
  logic        dest_ok;

  assign in_ready_o = push_ready_i;
  assign req_acc    = in_valid_i && push_ready_i;
  assign byte_in    = req_acc && (req_type_i == ais_pkg::REQ_FRAME);

  // byte parser, end of frame check and job build
  always_comb begin
    cnt_d   = cnt_q;
    et_d    = et_q;
    vlan_d  = vlan_q;
    ver_d   = ver_q;
    dest_d  = dest_q;
    off     = ais_pkg::OFF_ETH;
    dest_ok = 1'b0;
    push_valid_o        = 1'b0;
    push_job_o.kind     = ais_pkg::JOB_FRAME;
    push_job_o.dest_ok  = 1'b0;
    push_job_o.addr     = alias_address_i;

    if (byte_in && cnt_q != ais_pkg::COUNT_MAX) begin
      cnt_d = cnt_q + 7'd1;
      if (link_eth_i) begin
        if (cnt_q == ais_pkg::POS_ET_HI) begin
          et_d = {data_byte_i, 8'h00};
        end
        if (cnt_q == ais_pkg::POS_ET_LO) begin
          et_d = et_q | {8'h00, data_byte_i};
          if (et_d == ais_pkg::ET_VLAN) begin
            vlan_d = 1'b1;
          end
        end
        if (vlan_q && cnt_q == ais_pkg::POS_INNER_HI) begin
          et_d = {data_byte_i, 8'h00};
        end
        if (vlan_q && cnt_q == ais_pkg::POS_INNER_LO) begin
          et_d = et_q | {8'h00, data_byte_i};
        end
        off = vlan_d ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH;
        if (cnt_q >= off) begin
          if (et_d == ais_pkg::ET_IPV4) begin
            if (cnt_q == off) begin
              ver_d = data_byte_i[7:4];
            end
            if (cnt_q >= off + ais_pkg::IP_DST_FIRST && cnt_q <= off + ais_pkg::IP_DST_LAST) begin
              dest_d = {dest_q[23:0], data_byte_i};
            end
          end else if (et_d == ais_pkg::ET_ARP || et_d == ais_pkg::ET_RARP) begin
            if (cnt_q >= off + ais_pkg::ARP_DST_FIRST &&
                cnt_q <= off + ais_pkg::ARP_DST_LAST) begin
              dest_d = {dest_q[23:0], data_byte_i};
            end
          end
        end
      end else begin
        if (cnt_q == 7'd0) begin
          ver_d = data_byte_i[7:4];
        end
        if (cnt_q >= ais_pkg::IP_DST_FIRST && cnt_q <= ais_pkg::IP_DST_LAST) begin
          dest_d = {dest_q[23:0], data_byte_i};
        end
      end
    end

    // destination check on the updated parse state
    if (!link_eth_i) begin
      dest_ok = (cnt_d >= ais_pkg::IP_HDR_LEN) && (ver_d == ais_pkg::IP_VERSION_4);
    end else begin
      off = vlan_d ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH;
      if (cnt_d < ais_pkg::OFF_ETH || (vlan_d && cnt_d < ais_pkg::OFF_VLAN)) begin
        dest_ok = 1'b0;
      end else if (et_d == ais_pkg::ET_IPV4) begin
        dest_ok = (cnt_d >= off + ais_pkg::IP_HDR_LEN) && (ver_d == ais_pkg::IP_VERSION_4);
      end else if (et_d == ais_pkg::ET_ARP || et_d == ais_pkg::ET_RARP) begin
        dest_ok = (cnt_d >= off + ais_pkg::ARP_HDR_LEN);
      end else begin
        dest_ok = 1'b0;
      end
    end

    // job emit
    if (byte_in && frame_last_i) begin
      push_valid_o       = 1'b1;
      push_job_o.kind    = ais_pkg::JOB_FRAME;
      push_job_o.dest_ok = dest_ok;
      push_job_o.addr    = dest_d;
      cnt_d  = '0;
      et_d   = '0;
      vlan_d = 1'b0;
      ver_d  = '0;
      dest_d = '0;
    end else if (req_acc && req_type_i == ais_pkg::REQ_ADD) begin
      push_valid_o    = 1'b1;
      push_job_o.kind = ais_pkg::JOB_ADD;
    end else if (req_acc && req_type_i == ais_pkg::REQ_DEL) begin
      push_valid_o    = 1'b1;
      push_job_o.kind = ais_pkg::JOB_DEL;
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      et_q   <= '0;
      vlan_q <= 1'b0;
      ver_q  <= '0;
      dest_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      et_q   <= et_d;
      vlan_q <= vlan_d;
      ver_q  <= ver_d;
      dest_q <= dest_d;
    end
  end

endmodule

@@ hw/rtl/ais_queue.sv @@
// two-entry job queue between parser and table engine
module ais_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ais_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ais_pkg::job_t pop_job_o
);

  ais_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/ais_back.sv @@
// back end: alias table, lookups, commands and the result register
module ais_back #(
  parameter int unsigned NUM_ALIASES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   primary_ip_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  ais_pkg::job_t pop_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          result_kind_o,
  output logic [3:0]    target_o,
  output logic [1:0]    status_o,
  output logic [31:0]   dest_ip_o
);

  localparam int unsigned IDX_W = (NUM_ALIASES > 1) ? $clog2(NUM_ALIASES) : 1;

  logic [31:0]            table_q [NUM_ALIASES];
  logic [NUM_ALIASES-1:0] valid_q, valid_d;

  logic             out_valid_q;
  logic             kind_q, kind_d;
  logic [3:0]       target_q, target_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      dip_q, dip_d;

  logic             do_pop;
  logic             hit, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic [IDX_W:0]   hit_p1, free_p1;
  logic             wr_en;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign do_pop      = pop_valid_i && pop_ready_o;

  // parallel compare, lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = NUM_ALIASES - 1; i >= 0; i--) begin
      if (valid_q[i] && table_q[i] == pop_job_i.addr) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_p1  = {1'b0, hit_idx} + {{IDX_W{1'b0}}, 1'b1};
  assign free_p1 = {1'b0, free_idx} + {{IDX_W{1'b0}}, 1'b1};

  // job execution
  always_comb begin
    valid_d  = valid_q;
    wr_en    = 1'b0;
    kind_d   = ais_pkg::KIND_VERDICT;
    target_d = '0;
    status_d = ais_pkg::ST_OK;
    dip_d    = '0;
    case (pop_job_i.kind)
      ais_pkg::JOB_FRAME: begin
        if (pop_job_i.dest_ok) begin
          dip_d = pop_job_i.addr;
          if (pop_job_i.addr != primary_ip_i && hit) begin
            target_d = 4'(hit_p1);
          end
        end
      end
      ais_pkg::JOB_ADD: begin
        kind_d = ais_pkg::KIND_STATUS;
        if (pop_job_i.addr == '0) begin
          status_d = ais_pkg::ST_INVALID;
        end else if (pop_job_i.addr == primary_ip_i || hit) begin
          status_d = ais_pkg::ST_IN_USE;
        end else if (free_any) begin
          target_d = 4'(free_p1);
          wr_en    = do_pop;
          if (do_pop) begin
            valid_d[free_idx] = 1'b1;
          end
        end else begin
          status_d = ais_pkg::ST_FULL;
        end
      end
      ais_pkg::JOB_DEL: begin
        kind_d = ais_pkg::KIND_STATUS;
        if (pop_job_i.addr == '0 || !hit) begin
          status_d = ais_pkg::ST_INVALID;
        end else begin
          target_d = 4'(hit_p1);
          if (do_pop) begin
            valid_d[hit_idx] = 1'b0;
          end
        end
      end
      default: begin
        kind_d = ais_pkg::KIND_VERDICT;
      end
    endcase
  end

  // alias address storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[free_idx] <= pop_job_i.addr;
    end
  end

  // slot valid bits and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (do_pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      kind_q   <= kind_d;
      target_q <= target_d;
      status_q <= status_d;
      dip_q    <= dip_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign target_o      = target_q;
  assign status_o      = status_q;
  assign dest_ip_o     = dip_q;

endmodule

@@ hw/rtl/alias_ip_receive_steering.sv @@
// top level: config registers, parser, job queue and alias table engine
// a job is registered in the job queue, then its result in the result register
// throughput: one request per cycle while the queue has room, all slots compared at once
// a two-entry job queue holds two more results while the output stalls, then input stalls
// reset: alias slots empty, parse state cleared, primary_ip 0, link_is_ethernet 1
module alias_ip_receive_steering #(
  parameter int unsigned NUM_ALIASES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  logic [31:0] alias_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  target_o,
  output logic [1:0]  status_o,
  output logic [31:0] dest_ip_o
);

  logic [31:0]   primary_ip_q;
  logic          link_eth_q;

  logic          push_valid, push_ready;
  ais_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  ais_pkg::job_t pop_job;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_ip_q <= '0;
      link_eth_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ais_pkg::CFG_PRIMARY_IP: primary_ip_q <= cfg_data_i;
        ais_pkg::CFG_LINK_ETH:   link_eth_q   <= cfg_data_i[0];
        default: begin
          link_eth_q <= link_eth_q;
        end
      endcase
    end
  end

  // request parser
  ais_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .link_eth_i      (link_eth_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .frame_last_i    (frame_last_i),
    .alias_address_i (alias_address_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_job_o      (push_job)
  );

  // job queue
  ais_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // alias table engine
  ais_back #(
    .NUM_ALIASES (NUM_ALIASES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .primary_ip_i  (primary_ip_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_job_i     (pop_job),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .target_o      (target_o),
    .status_o      (status_o),
    .dest_ip_o     (dest_ip_o)
  );

endmodule

@@ tb/alias_steer_checker.sv @@
`timescale 1ns / 1ps
// checker for the alias ip receive steering block: mirrors the block, predicts and compares results
module alias_steer_checker #(
  parameter int unsigned NUM_ALIASES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  logic [31:0] alias_address_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [3:0]  target_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] dest_ip_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // one result as the block presents it
  typedef struct packed {
    logic        kind;
    logic [3:0]  target;
    logic [1:0]  status;
    logic [31:0] dest;
  } steer_result_t;

  steer_result_t steer_expected_q[$];

  // mirrored configuration and alias table
  logic [31:0] primary_ip;
  logic        link_eth;
  logic [31:0] alias_addr [NUM_ALIASES];
  logic        alias_used [NUM_ALIASES];

  // mirrored frame parse state
  int unsigned byte_cnt;
  logic [15:0] etype;
  logic        vlan;
  logic [3:0]  ip_ver;
  logic [31:0] dest_acc;

  function automatic void clear_frame();
    byte_cnt = 0;
    etype    = '0;
    vlan     = 1'b0;
    ip_ver   = '0;
    dest_acc = '0;
  endfunction

  // lowest valid slot holding the address, -1 when absent
  function automatic int find_slot(logic [31:0] addr);
    int i;
    for (i = 0; i < NUM_ALIASES; i++) begin
      if (alias_used[i] && alias_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // parse one frame byte under the current link mode
  function automatic void take_byte(logic [7:0] b);
    int unsigned i;
    int unsigned off;
    i = byte_cnt;
    if (i >= ais_pkg::COUNT_MAX) return;
    byte_cnt = i + 1;
    if (link_eth) begin
      if (i == ais_pkg::POS_ET_HI) etype = {b, 8'h00};
      if (i == ais_pkg::POS_ET_LO) begin
        etype = etype | {8'h00, b};
        if (etype == ais_pkg::ET_VLAN) vlan = 1'b1;
      end
      if (vlan && i == ais_pkg::POS_INNER_HI) etype = {b, 8'h00};
      if (vlan && i == ais_pkg::POS_INNER_LO) etype = etype | {8'h00, b};
      off = vlan ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH;
      if (i < off) return;
      if (etype == ais_pkg::ET_IPV4) begin
        if (i == off) ip_ver = b[7:4];
        if (i >= off + ais_pkg::IP_DST_FIRST && i <= off + ais_pkg::IP_DST_LAST)
          dest_acc = {dest_acc[23:0], b};
      end else if (etype == ais_pkg::ET_ARP || etype == ais_pkg::ET_RARP) begin
        if (i >= off + ais_pkg::ARP_DST_FIRST && i <= off + ais_pkg::ARP_DST_LAST)
          dest_acc = {dest_acc[23:0], b};
      end
    end else begin
      if (i == 0) ip_ver = b[7:4];
      if (i >= ais_pkg::IP_DST_FIRST && i <= ais_pkg::IP_DST_LAST)
        dest_acc = {dest_acc[23:0], b};
    end
  endfunction

  // whether the frame seen so far carries a usable destination
  function automatic logic frame_has_dest();
    int unsigned off;
    if (!link_eth)
      return byte_cnt >= ais_pkg::IP_HDR_LEN && ip_ver == ais_pkg::IP_VERSION_4;
    if (byte_cnt < ais_pkg::OFF_ETH) return 1'b0;
    if (vlan && byte_cnt < ais_pkg::OFF_VLAN) return 1'b0;
    off = vlan ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH;
    if (etype == ais_pkg::ET_IPV4)
      return byte_cnt >= off + ais_pkg::IP_HDR_LEN && ip_ver == ais_pkg::IP_VERSION_4;
    if (etype == ais_pkg::ET_ARP || etype == ais_pkg::ET_RARP)
      return byte_cnt >= off + ais_pkg::ARP_HDR_LEN;
    return 1'b0;
  endfunction

  function automatic void post(logic kind, logic [3:0] tgt, logic [1:0] st, logic [31:0] dip);
    steer_result_t r;
    r.kind   = kind;
    r.target = tgt;
    r.status = st;
    r.dest   = dip;
    steer_expected_q.push_back(r);
  endfunction

  // work out what one accepted request causes
  function automatic void predict_steering(logic [1:0] req, logic [7:0] b, logic last,
                                           logic [31:0] addr);
    int          slot;
    int          i;
    logic [31:0] dip;
    logic [3:0]  tgt;
    case (req)
      ais_pkg::REQ_FRAME: begin
        take_byte(b);
        if (last) begin
          dip = '0;
          tgt = '0;
          if (frame_has_dest()) begin
            dip = dest_acc;
            if (dip != primary_ip) begin
              slot = find_slot(dip);
              if (slot >= 0) tgt = 4'(slot + 1);
            end
          end
          clear_frame();
          post(ais_pkg::KIND_VERDICT, tgt, ais_pkg::ST_OK, dip);
        end
      end
      ais_pkg::REQ_ADD: begin
        if (addr == '0) begin
          post(ais_pkg::KIND_STATUS, 4'd0, ais_pkg::ST_INVALID, '0);
        end else if (addr == primary_ip || find_slot(addr) >= 0) begin
          post(ais_pkg::KIND_STATUS, 4'd0, ais_pkg::ST_IN_USE, '0);
        end else begin
          slot = -1;
          for (i = 0; i < NUM_ALIASES; i++) begin
            if (!alias_used[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            post(ais_pkg::KIND_STATUS, 4'd0, ais_pkg::ST_FULL, '0);
          end else begin
            alias_used[slot] = 1'b1;
            alias_addr[slot] = addr;
            post(ais_pkg::KIND_STATUS, 4'(slot + 1), ais_pkg::ST_OK, '0);
          end
        end
      end
      ais_pkg::REQ_DEL: begin
        slot = (addr == '0) ? -1 : find_slot(addr);
        if (slot < 0) begin
          post(ais_pkg::KIND_STATUS, 4'd0, ais_pkg::ST_INVALID, '0);
        end else begin
          alias_used[slot] = 1'b0;
          post(ais_pkg::KIND_STATUS, 4'(slot + 1), ais_pkg::ST_OK, '0);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // compare one delivered result with the oldest prediction
  task automatic compare_result();
    steer_result_t want;
    if (steer_expected_q.size() == 0) begin
      report_mismatch("unrequested result", dest_ip_i, '0);
      return;
    end
    want = steer_expected_q.pop_front();
    checked_o++;
    if (result_kind_i !== want.kind) report_mismatch("result_kind", result_kind_i, want.kind);
    if (target_i !== want.target) report_mismatch("target", target_i, want.target);
    if (status_i !== want.status) report_mismatch("status", status_i, want.status);
    if (dest_ip_i !== want.dest) report_mismatch("dest_ip", dest_ip_i, want.dest);
  endtask

  // track every handshake at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_ip   = '0;
      link_eth     = 1'b1;
      alias_used   = '{default: 1'b0};
      fail_count_o = 0;
      checked_o    = 0;
      clear_frame();
      steer_expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i)
        predict_steering(req_type_i, data_byte_i, frame_last_i, alias_address_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == ais_pkg::CFG_PRIMARY_IP) primary_ip = cfg_data_i;
        else link_eth = cfg_data_i[0];
      end
    end
    pending_o = steer_expected_q.size();
  end

endmodule

@@ tb/alias_ip_receive_steering_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the alias ip receive steering block: stimulus, stalls and verdict
module alias_ip_receive_steering_tb;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned ITEM_GOAL  = 1950;
  localparam int unsigned CALM_TAIL  = 300;
  localparam int unsigned POOL_SIZE  = 12;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = ais_pkg::CFG_PRIMARY_IP;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = ais_pkg::REQ_FRAME;
  logic [7:0]  data_byte = '0;
  logic        frame_last = 1'b0;
  logic [31:0] alias_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [3:0]  target;
  logic [1:0]  status;
  logic [31:0] dest_ip;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping
  int unsigned items_sent;
  int unsigned frames_sent;
  int unsigned cmds_sent;
  int unsigned cfg_writes;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  logic [31:0] cur_primary;
  logic        cur_eth;
  logic [31:0] addr_pool [POOL_SIZE];
  logic [7:0]  frame_buf [$];

  alias_ip_receive_steering #(
    .NUM_ALIASES(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .data_byte_i    (data_byte),
    .frame_last_i   (frame_last),
    .alias_address_i(alias_addr),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .target_o       (target),
    .status_o       (status),
    .dest_ip_o      (dest_ip)
  );

  alias_steer_checker #(
    .NUM_ALIASES(SLOTS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .data_byte_i    (data_byte),
    .frame_last_i   (frame_last),
    .alias_address_i(alias_addr),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .target_i       (target),
    .status_i       (status),
    .dest_ip_i      (dest_ip),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side back-pressure in bursts, each started with a chance of stall_pct percent
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // register write, only once the block has drained
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == ais_pkg::CFG_PRIMARY_IP) cur_primary = value;
    else cur_eth = value[0];
    cfg_writes++;
  endtask

  // one request on the input channel, with an optional leading gap
  task automatic send_req(input logic [1:0] kind, input logic [7:0] b, input logic last,
                          input logic [31:0] addr);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    data_byte  <= b;
    frame_last <= last;
    alias_addr <= addr;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] kind, input logic [31:0] addr);
    send_req(kind, 8'($urandom), 1'($urandom), addr);
    cmds_sent++;
  endtask

  // bytes needed for a complete header of the given kind
  function automatic int unsigned header_len(logic vlan, logic [15:0] et);
    if (!cur_eth) return ais_pkg::IP_HDR_LEN;
    return (vlan ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH) +
           ((et == ais_pkg::ET_ARP || et == ais_pkg::ET_RARP) ?
            ais_pkg::ARP_HDR_LEN : ais_pkg::IP_HDR_LEN);
  endfunction

  function automatic void put_byte(int unsigned pos, logic [7:0] v);
    if (pos < frame_buf.size()) frame_buf[pos] = v;
  endfunction

  // frame of random filler with the header fields laid over it
  task automatic build_frame(input logic vlan, input logic [15:0] et, input logic [3:0] ver,
                             input logic [31:0] dst, input int unsigned len);
    int unsigned off;
    int unsigned dpos;
    int unsigned k;
    logic [15:0] outer;
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    off  = 0;
    dpos = ais_pkg::IP_DST_FIRST;
    if (cur_eth) begin
      outer = vlan ? ais_pkg::ET_VLAN : et;
      put_byte(ais_pkg::POS_ET_HI, outer[15:8]);
      put_byte(ais_pkg::POS_ET_LO, outer[7:0]);
      if (vlan) begin
        put_byte(ais_pkg::POS_INNER_HI, et[15:8]);
        put_byte(ais_pkg::POS_INNER_LO, et[7:0]);
      end
      off  = vlan ? ais_pkg::OFF_VLAN : ais_pkg::OFF_ETH;
      dpos = off + ((et == ais_pkg::ET_ARP || et == ais_pkg::ET_RARP) ?
                    ais_pkg::ARP_DST_FIRST : ais_pkg::IP_DST_FIRST);
    end
    put_byte(off, {ver, 4'h5});
    for (k = 0; k < 4; k++) put_byte(dpos + k, dst[31 - 8 * k -: 8]);
  endtask

  function automatic logic [31:0] pick_dest();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 7) return cur_primary;
    return 32'($urandom);
  endfunction

  function automatic logic [31:0] pick_cmd_addr();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return cur_primary;
    if (r == 2) return 32'($urandom);
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) send_cmd(ais_pkg::REQ_ADD, pick_cmd_addr());
    else if (r < 95) send_cmd(ais_pkg::REQ_DEL, pick_cmd_addr());
    else send_cmd(REQ_UNUSED, 32'($urandom));
  endtask

  // stream the built frame, optionally with a command in the middle
  task automatic send_frame(input logic with_cmd);
    int unsigned k;
    for (k = 0; k < frame_buf.size(); k++) begin
      if (with_cmd && k == frame_buf.size() / 2) random_cmd();
      send_req(ais_pkg::REQ_FRAME, frame_buf[k], k == frame_buf.size() - 1, 32'($urandom));
    end
    frames_sent++;
  endtask

  // mostly well-formed frames, some truncated, oversized or pure noise
  task automatic random_frame();
    int unsigned r;
    int unsigned n;
    logic [15:0] et;
    logic        vl;
    logic [3:0]  ver;
    r = $urandom_range(0, 19);
    if (r < 10) et = ais_pkg::ET_IPV4;
    else if (r < 13) et = ais_pkg::ET_ARP;
    else if (r < 16) et = ais_pkg::ET_RARP;
    else if (r < 17) et = ais_pkg::ET_VLAN;
    else et = 16'($urandom);
    vl  = ($urandom_range(0, 3) == 0);
    ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : ais_pkg::IP_VERSION_4;
    n   = header_len(vl, et) + $urandom_range(0, 8);
    r   = $urandom_range(0, 99);
    if (r < 8) n = $urandom_range(1, n);
    else if (r < 10) n = $urandom_range(120, 150);
    build_frame(vl, et, ver, pick_dest(), n);
    if (r >= 10 && r < 15) foreach (frame_buf[k]) frame_buf[k] = 8'($urandom);
    send_frame($urandom_range(0, 24) == 0);
  endtask

  initial begin
    int unsigned k;
    int unsigned r;
    int unsigned goal;
    int unsigned phase_end;

    items_sent  = 0;
    frames_sent = 0;
    cmds_sent   = 0;
    cfg_writes  = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    stall_left  = 0;
    cur_primary = '0;
    cur_eth     = 1'b1;

    // apply reset, then release it
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // table commands: rejects, fill to full, free and reuse a slot
    cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'h0A00_0001);
    send_cmd(ais_pkg::REQ_ADD, 32'h0000_0000);
    send_cmd(ais_pkg::REQ_ADD, 32'h0A00_0001);
    for (k = 0; k < SLOTS; k++) send_cmd(ais_pkg::REQ_ADD, 32'hC0A8_0100 + k);
    send_cmd(ais_pkg::REQ_ADD, 32'hFFFF_FFFF);
    send_cmd(ais_pkg::REQ_ADD, 32'hC0A8_0103);
    send_cmd(ais_pkg::REQ_DEL, 32'h0000_0000);
    send_cmd(ais_pkg::REQ_DEL, 32'hDEAD_BEEF);
    send_cmd(ais_pkg::REQ_DEL, 32'hC0A8_0102);
    send_cmd(ais_pkg::REQ_ADD, 32'hFFFF_FFFF);
    send_cmd(REQ_UNUSED, 32'hC0A8_0101);

    // frame kinds: alias hits, primary, unmatched, oversized, and ways to fall short
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hFFFF_FFFF,
                header_len(1'b0, ais_pkg::ET_IPV4));
    send_frame(1'b0);
    build_frame(1'b1, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0107,
                header_len(1'b1, ais_pkg::ET_IPV4) + 4);
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_ARP, ais_pkg::IP_VERSION_4, 32'h0A00_0001,
                header_len(1'b0, ais_pkg::ET_ARP));
    send_frame(1'b0);
    build_frame(1'b1, ais_pkg::ET_RARP, ais_pkg::IP_VERSION_4, 32'hC0A8_0100,
                header_len(1'b1, ais_pkg::ET_RARP));
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'h0102_0304, 40);
    send_frame(1'b1);
    build_frame(1'b0, ais_pkg::ET_IPV4, 4'd6, 32'hC0A8_0101, 40);
    send_frame(1'b0);
    build_frame(1'b0, 16'h86DD, ais_pkg::IP_VERSION_4, 32'hC0A8_0101, 40);
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0101, 33);
    send_frame(1'b0);
    build_frame(1'b1, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0101, 17);
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0101, 13);
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0101, 1);
    send_frame(1'b0);
    build_frame(1'b1, ais_pkg::ET_ARP, ais_pkg::IP_VERSION_4, 32'hC0A8_0104, 150);
    send_frame(1'b0);

    // primary moved onto an alias address takes precedence
    cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'hC0A8_0105);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0105, 34);
    send_frame(1'b0);
    cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'hFFFF_FFFF);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hFFFF_FFFF, 34);
    send_frame(1'b0);

    // bare ip link, full and short header
    cfg_write(ais_pkg::CFG_LINK_ETH, 32'd0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0104, 20);
    send_frame(1'b0);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0104, 19);
    send_frame(1'b0);

    // link mode flipped in the middle of a frame
    cfg_write(ais_pkg::CFG_LINK_ETH, 32'd1);
    build_frame(1'b0, ais_pkg::ET_IPV4, ais_pkg::IP_VERSION_4, 32'hC0A8_0106, 34);
    for (k = 0; k < 10; k++) send_req(ais_pkg::REQ_FRAME, frame_buf[k], 1'b0, 32'($urandom));
    cfg_write(ais_pkg::CFG_LINK_ETH, 32'd0);
    for (k = 10; k < frame_buf.size(); k++)
      send_req(ais_pkg::REQ_FRAME, frame_buf[k], k == frame_buf.size() - 1, 32'($urandom));
    frames_sent++;
    cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'h0000_0000);

    // address pool shared by commands and frame destinations
    addr_pool[0] = 32'hFFFF_FFFF;
    addr_pool[1] = 32'h0000_0001;
    addr_pool[2] = 32'h8000_0000;
    for (k = 3; k < POOL_SIZE; k++) addr_pool[k] = 32'($urandom);

    // random phases, each under its own settings and idling
    goal = ITEM_GOAL;
    while (items_sent < goal) begin
      cfg_write(ais_pkg::CFG_LINK_ETH, 32'($urandom_range(0, 3) != 0));
      r = $urandom_range(0, 9);
      if (r == 0) cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'h0000_0000);
      else if (r == 1) cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'hFFFF_FFFF);
      else if (r < 5)
        cfg_write(ais_pkg::CFG_PRIMARY_IP, addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
      else cfg_write(ais_pkg::CFG_PRIMARY_IP, 32'($urandom));
      r = $urandom_range(0, 2);
      gap_pct   = (r == 0) ? 0 : (r == 1) ? 10 : 30;
      r = $urandom_range(0, 2);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 30;
      phase_end = items_sent + $urandom_range(100, 250);
      while (items_sent < phase_end && items_sent < goal) begin
        if (items_sent + CALM_TAIL >= goal) begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        if ($urandom_range(0, 4) == 0) random_cmd();
        else random_frame();
      end
    end

    // drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("run covered %0d requests: %0d frames, %0d table commands, %0d register writes",
             items_sent, frames_sent, cmds_sent, cfg_writes);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ais_pkg.sv
hw/rtl/ais_front.sv
hw/rtl/ais_queue.sv
hw/rtl/ais_back.sv
hw/rtl/alias_ip_receive_steering.sv
tb/alias_steer_checker.sv
tb/alias_ip_receive_steering_tb.sv
